// ===== sv/mmas_pkg.sv =====
`default_nettype none

package mmas_pkg;

  // Field widths.
  localparam int unsigned AddrW   = 64;
  localparam int unsigned TypeW   = 32;
  localparam int unsigned KibW    = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;
  // Width of the start adjustment plus the reserve.
  localparam int unsigned CutW    = 25;
  localparam int unsigned AdjW    = 24;

  // Address and size constants.
  localparam logic [AddrW-1:0] LowLimit     = 64'h0000_0000_0010_0000;
  localparam logic [AddrW-1:0] ArenaFloor   = 64'h0000_0000_0080_0000;
  localparam logic [AddrW-1:0] ArenaGap     = 64'h0000_0000_0020_0000;
  localparam logic [AddrW-1:0] ArenaReserve = 64'h0000_0000_0100_0000;
  localparam logic [AddrW-1:0] ArenaMin     = 64'h0000_0000_0200_0000;
  localparam logic [AddrW-1:0] PageMask     = ~64'h0000_0000_0000_0fff;

  // Region type codes.
  localparam logic [TypeW-1:0] TypeAvail = 32'd1;
  localparam logic [TypeW-1:0] TypeAcpi  = 32'd3;
  localparam logic [TypeW-1:0] TypeNvs   = 32'd4;

  typedef enum logic {
    KindRegion = 1'b0,
    KindEnd    = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFallbackEn  = 1'b0,
    CfgFallbackKib = 1'b1
  } cfg_idx_e;

  // Candidate region captured when the end of the map arrives.
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
    logic [AddrW-1:0] total;
    logic             fb_used;
  } cand_t;

endpackage

`default_nettype wire

// ===== sv/memory_map_arena_selector_core.sv =====
// An end request is captured when it is accepted; its result then passes the
// shaping register and the result register before it is on the output.
// Throughput: one request per cycle while in_stall_o is low; region requests give no result.
// Reset (rst_ni low, asynchronous) clears the candidate, the RAM total, the
// configuration registers and all valid flags.
`default_nettype none

module memory_map_arena_selector_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration writes.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mmas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mmas_pkg::CfgDataW-1:0] cfg_data_i,
  // Request channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [63:0]                   region_base_i,
  input  wire logic [63:0]                   region_length_i,
  input  wire logic [31:0]                   region_type_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               arena_ok_o,
  output logic [63:0]                        arena_base_o,
  output logic [63:0]                        arena_bytes_o,
  output logic [63:0]                        phys_total_o
);

  logic                          fb_en_q;
  logic [mmas_pkg::KibW-1:0]     fb_kib_q;

  logic [mmas_pkg::AddrW-1:0]    best_base_q, best_base_d;
  logic [mmas_pkg::AddrW-1:0]    best_len_q, best_len_d;
  logic [mmas_pkg::AddrW-1:0]    total_q, total_d;

  logic                          s1_v_q, s1_v_d;
  mmas_pkg::cand_t               s1_cand_q, s1_cand_d;

  logic                          shape_ready;
  logic                          s1_adv;
  logic                          in_acc;
  logic                          is_end;
  logic                          counts_ram;
  logic                          better;
  logic [mmas_pkg::AddrW:0]      sum;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_en_q  <= 1'b0;
      fb_kib_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (mmas_pkg::cfg_idx_e'(cfg_index_i))
        mmas_pkg::CfgFallbackEn:  fb_en_q  <= cfg_data_i[0];
        mmas_pkg::CfgFallbackKib: fb_kib_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input handshake follows the capture stage.
  assign s1_adv     = !s1_v_q || shape_ready;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_end     = (kind_i == mmas_pkg::KindEnd);

  // Region bookkeeping and capture of the candidate on the end of the map.
  always_comb begin
    counts_ram = (region_type_i == mmas_pkg::TypeAvail) ||
                 (region_type_i == mmas_pkg::TypeAcpi)  ||
                 (region_type_i == mmas_pkg::TypeNvs);
    better     = (region_type_i == mmas_pkg::TypeAvail) &&
                 (region_length_i > best_len_q) &&
                 (region_base_i >= mmas_pkg::LowLimit);
    sum        = {1'b0, total_q} + {1'b0, region_length_i};

    best_base_d = best_base_q;
    best_len_d  = best_len_q;
    total_d     = total_q;

    if (fb_en_q && (best_len_q == '0)) begin
      s1_cand_d.base    = mmas_pkg::LowLimit;
      s1_cand_d.len     = {{(mmas_pkg::AddrW - mmas_pkg::KibW - 10){1'b0}}, fb_kib_q, 10'b0};
      s1_cand_d.fb_used = 1'b1;
    end else begin
      s1_cand_d.base    = best_base_q;
      s1_cand_d.len     = best_len_q;
      s1_cand_d.fb_used = 1'b0;
    end
    s1_cand_d.total = total_q;

    s1_v_d = s1_v_q;
    if (s1_adv) begin
      s1_v_d = in_acc && is_end;
    end

    if (in_acc) begin
      if (is_end) begin
        best_base_d = '0;
        best_len_d  = '0;
        total_d     = '0;
      end else begin
        if (counts_ram) begin
          total_d = sum[mmas_pkg::AddrW] ? '1 : sum[mmas_pkg::AddrW-1:0];
        end
        if (better) begin
          best_base_d = region_base_i;
          best_len_d  = region_length_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_base_q <= '0;
      best_len_q  <= '0;
      total_q     <= '0;
      s1_v_q      <= 1'b0;
    end else begin
      best_base_q <= best_base_d;
      best_len_q  <= best_len_d;
      total_q     <= total_d;
      s1_v_q      <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_cand_q <= s1_cand_d;
    end
  end

  // Shaping and result register.
  mmas_shape u_shape (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (s1_v_q),
    .cand_i       (s1_cand_q),
    .cand_ready_o (shape_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .arena_ok_o   (arena_ok_o),
    .arena_base_o (arena_base_o),
    .arena_bytes_o(arena_bytes_o),
    .phys_total_o (phys_total_o)
  );

`ifndef SYNTH
  // An accepted end request is captured for shaping.
  a_end_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_end) |=> s1_v_q)
    else $error("end request not captured");

  // The state is cleared after an end request.
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_end) |=> ((total_q == '0) && (best_len_q == '0) && (best_base_q == '0)))
    else $error("state not cleared after end request");

  // A region request never enters the shaping path.
  a_region_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_end && s1_adv) |=> !s1_v_q)
    else $error("region request entered shaping");

  // A usable arena has a page-aligned size of at least the minimum.
  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && arena_ok_o) |->
      ((arena_bytes_o[11:0] == 12'h000) && (arena_bytes_o >= mmas_pkg::ArenaMin)))
    else $error("usable arena below minimum or unaligned");

  // No arena means zero base and size.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !arena_ok_o) |-> ((arena_base_o == '0) && (arena_bytes_o == '0)))
    else $error("failed arena with non-zero fields");
`endif

endmodule

`default_nettype wire

// ===== sv/mmas_shape.sv =====
`default_nettype none

module mmas_shape (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cand_valid_i,
  input  wire mmas_pkg::cand_t   cand_i,
  output logic                   cand_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   arena_ok_o,
  output logic [63:0]            arena_base_o,
  output logic [63:0]            arena_bytes_o,
  output logic [63:0]            phys_total_o
);

  logic                          out_ready;
  logic                          s2_adv;

  logic                          s2_v_q;
  logic [mmas_pkg::AddrW-1:0]    s2_base_q, s2_base_d;
  logic [mmas_pkg::AddrW-1:0]    s2_len_q;
  logic [mmas_pkg::AddrW-1:0]    s2_total_q, s2_total_d;
  logic [mmas_pkg::CutW-1:0]     s2_cut_q, s2_cut_d;
  logic                          s2_ge_min_q, s2_ge_min_d;

  logic                          base_low;
  logic [mmas_pkg::AdjW-1:0]     adj;

  logic [mmas_pkg::AddrW-1:0]    len3;
  logic                          ok;

  logic                          out_v_q;
  logic                          ok_q;
  logic [mmas_pkg::AddrW-1:0]    base_q, bytes_q, total_q;

  // Flow control: each stage moves when the one after it can take a request.
  assign out_ready    = !out_v_q || !out_stall_i;
  assign s2_adv       = !s2_v_q || out_ready;
  assign cand_ready_o = s2_adv;

  // Stage two: start adjustment, moved base, minimum check and total fix-up.
  always_comb begin
    base_low    = (cand_i.base < mmas_pkg::ArenaFloor);
    adj         = base_low ? (mmas_pkg::ArenaFloor[mmas_pkg::AdjW-1:0]
                              - cand_i.base[mmas_pkg::AdjW-1:0])
                           : mmas_pkg::ArenaGap[mmas_pkg::AdjW-1:0];
    s2_cut_d    = {1'b0, adj} + mmas_pkg::ArenaReserve[mmas_pkg::CutW-1:0];
    s2_base_d   = base_low ? mmas_pkg::ArenaFloor : (cand_i.base + mmas_pkg::ArenaGap);
    s2_ge_min_d = (cand_i.len >= mmas_pkg::ArenaMin);
    s2_total_d  = (cand_i.fb_used && (cand_i.total == '0))
                  ? (mmas_pkg::LowLimit + cand_i.len) : cand_i.total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_adv) begin
      s2_v_q <= cand_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_base_q   <= s2_base_d;
      s2_len_q    <= cand_i.len;
      s2_total_q  <= s2_total_d;
      s2_cut_q    <= s2_cut_d;
      s2_ge_min_q <= s2_ge_min_d;
    end
  end

  // Stage three: take off the adjustment and the reserve, then check the size.
  // A candidate of at least the minimum never drops to the reserve, so the
  // reserve is always taken off.
  always_comb begin
    len3 = s2_len_q - {{(mmas_pkg::AddrW - mmas_pkg::CutW){1'b0}}, s2_cut_q};
    ok   = s2_ge_min_q && (len3 >= mmas_pkg::ArenaMin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      ok_q    <= ok;
      base_q  <= ok ? s2_base_q : '0;
      bytes_q <= ok ? (len3 & mmas_pkg::PageMask) : '0;
      total_q <= s2_total_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign arena_ok_o    = ok_q;
  assign arena_base_o  = base_q;
  assign arena_bytes_o = bytes_q;
  assign phys_total_o  = total_q;

endmodule

`default_nettype wire
